// File: rtl/restricted_partition_count_unrank_defines.svh
// ----------------------------------------------------------------------------
// restricted_partition_count_unrank_defines
// Assertion macros for the checker file of the partition unranker.
// ----------------------------------------------------------------------------
`ifndef RESTRICTED_PARTITION_COUNT_UNRANK_DEFINES_SVH
`define RESTRICTED_PARTITION_COUNT_UNRANK_DEFINES_SVH

// The condition holds on every clock edge outside reset.
`define RPCU_ASSERT_HOLD(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rpcu check failed");

// The antecedent on one edge forces the consequent on the next edge.
`define RPCU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rpcu check failed");

`endif

// File: rtl/rpcu_pkg.sv
// ----------------------------------------------------------------------------
// rpcu_pkg
// Types and constants shared by the restricted partition unranker modules.
// ----------------------------------------------------------------------------
package rpcu_pkg;

    localparam int MAX_N_DEF      = 31;
    localparam int MAX_LIMIT_DEF  = 31;
    localparam int MAX_PARTS_DEF  = 31;
    localparam int MAX_RESULTS    = 31;
    localparam int KW             = $clog2(MAX_RESULTS + 1);
    localparam int COUNT_W        = 32;
    localparam int FRAC_W         = 32;
    localparam int SIZE_W         = 6;
    localparam int PART_W         = 5;
    localparam int ERR_W          = 2;
    localparam int IN_DATA_W      = 56;
    localparam int OUT_DATA_W     = 40;

    localparam logic [ERR_W-1:0] ERR_OK        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_RANGE     = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ZERO_FRAC = 2'd2;

    typedef enum logic [1:0] {
        EMIT_RANGE,
        EMIT_EMPTY,
        EMIT_ZFRAC,
        EMIT_NOPART
    } emit_kind_t;

    typedef enum logic [3:0] {
        S_FILL_RD,
        S_FILL_WR,
        S_IDLE,
        S_RD_TOTAL,
        S_CAP_TOTAL,
        S_CHECK,
        S_MUL,
        S_WHICH,
        S_WALK_RD,
        S_WALK_CMP,
        S_EMIT_PART,
        S_EMIT_ONE
    } state_t;

    typedef struct packed {
        logic       fill_rd;
        logic       fill_wr;
        logic       load_in;
        logic       rd_total;
        logic       cap_total;
        logic       mul;
        logic       set_which;
        logic       walk_init;
        logic       walk_rd;
        logic       walk_step;
        logic       take_part;
        logic       emit_one;
        emit_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic fill_last;
        logic range_err;
        logic total_zero;
        logic frac_zero;
        logic n_zero;
        logic walk_hit;
        logic part_last;
        logic out_free;
    } status_t;

endpackage

// File: rtl/rpcu_ctrl.sv
// ----------------------------------------------------------------------------
// rpcu_ctrl
// Sequencer for the table fill after reset, the count lookup and the walk.
// ----------------------------------------------------------------------------
module rpcu_ctrl
    import rpcu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    emit_kind_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL_RD;
            kind_reg  <= EMIT_RANGE;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_FILL_RD:
            begin
                cmd.fill_rd = 1'b1;
                state_next  = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                cmd.fill_wr = 1'b1;
                state_next  = status.fill_last ? S_IDLE : S_FILL_RD;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_RD_TOTAL;
                end
            end
            S_RD_TOTAL:
            begin
                if (status.range_err)
                begin
                    kind_next  = EMIT_RANGE;
                    state_next = S_EMIT_ONE;
                end
                else
                begin
                    cmd.rd_total = 1'b1;
                    state_next   = S_CAP_TOTAL;
                end
            end
            S_CAP_TOTAL:
            begin
                cmd.cap_total = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.total_zero)
                begin
                    kind_next  = EMIT_EMPTY;
                    state_next = S_EMIT_ONE;
                end
                else if (status.frac_zero)
                begin
                    kind_next  = EMIT_ZFRAC;
                    state_next = S_EMIT_ONE;
                end
                else if (status.n_zero)
                begin
                    kind_next  = EMIT_NOPART;
                    state_next = S_EMIT_ONE;
                end
                else
                begin
                    cmd.mul    = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_WHICH;
            end
            S_WHICH:
            begin
                cmd.set_which = 1'b1;
                cmd.walk_init = 1'b1;
                state_next    = S_WALK_RD;
            end
            S_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = S_WALK_CMP;
            end
            S_WALK_CMP:
            begin
                if (status.walk_hit)
                begin
                    state_next = S_EMIT_PART;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_WALK_RD;
                end
            end
            S_EMIT_PART:
            begin
                if (status.out_free)
                begin
                    cmd.take_part = 1'b1;
                    if (status.part_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = S_WALK_RD;
                    end
                end
            end
            S_EMIT_ONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_one = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/rpcu_datapath.sv
// ----------------------------------------------------------------------------
// rpcu_datapath
// Count table memory, query registers, rank arithmetic and output register.
// ----------------------------------------------------------------------------
module rpcu_datapath
    import rpcu_pkg::*;
#(
    parameter int MAX_N     = MAX_N_DEF,
    parameter int MAX_LIMIT = MAX_LIMIT_DEF,
    parameter int MAX_PARTS = MAX_PARTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic [IN_DATA_W-1:0]  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data, // count, part_value, part_valid, error_code
    output logic                  out_last
);

    localparam int NW    = $clog2(MAX_N + 1);
    localparam int LW    = $clog2(MAX_LIMIT + 1);
    localparam int MW    = $clog2(MAX_PARTS + 1);
    localparam int IW    = NW + LW + MW;
    localparam int DEPTH = 1 << IW;
    localparam int DW    = ((NW > LW) ? NW : LW) + 1;

    logic [COUNT_W-1:0] mem [0:DEPTH-1];

    logic [NW-1:0]        n_reg;
    logic [LW-1:0]        l_reg, i_reg;
    logic [MW-1:0]        m_reg;
    logic [FRAC_W-1:0]    frac_reg;
    logic                 range_reg;
    logic [COUNT_W-1:0]   total_reg, which_reg, rda_reg, rdb_reg;
    logic [2*COUNT_W-1:0] prod_reg;
    logic [KW-1:0]        k_reg;
    logic [IW-1:0]        fill_reg;

    logic                 out_valid_reg;
    logic [COUNT_W-1:0]   out_count_reg;
    logic [PART_W-1:0]    out_part_reg;
    logic                 out_pvalid_reg, out_last_reg;
    logic [ERR_W-1:0]     out_err_reg;

    logic [SIZE_W-1:0]    in_n, in_l, in_m;
    logic [NW-1:0]        fn;
    logic [LW-1:0]        fl;
    logic [MW-1:0]        fm;
    logic [DW-1:0]        f_diff, n_diff, top;
    logic [IW-1:0]        addr_a, addr_b;
    logic [COUNT_W-1:0]   fill_val, cand;
    logic                 out_free;

    assign in_n = in_data[5:0];
    assign in_l = in_data[11:6];
    assign in_m = in_data[17:12];

    assign fn = fill_reg[IW-1 -: NW];
    assign fl = fill_reg[MW +: LW];
    assign fm = fill_reg[MW-1:0];

    assign f_diff = DW'(fn) - DW'(fl);
    assign n_diff = DW'(n_reg) - DW'(i_reg);
    assign top    = (DW'(l_reg) < DW'(n_reg)) ? DW'(l_reg) : DW'(n_reg);

    // Port A serves the same-size neighbor during the fill and the total lookup;
    // port B serves the entry with the largest part removed.
    always_comb
    begin
        if (cmd.fill_rd)
        begin
            addr_a = {fn, fl - LW'(1), fm};
            addr_b = {f_diff[NW-1:0], fl, fm - MW'(1)};
        end
        else
        begin
            addr_a = {n_reg, l_reg, m_reg};
            addr_b = {n_diff[NW-1:0], i_reg, m_reg - MW'(1)};
        end
    end

    // p(n,l,m) = p(n,l-1,m) + p(n-l,l,m-1), with p(0,.,.) = 1.
    always_comb
    begin
        if (fn == '0)
        begin
            fill_val = COUNT_W'(1);
        end
        else if (fl == '0 || fm == '0)
        begin
            fill_val = '0;
        end
        else
        begin
            fill_val = rda_reg + ((DW'(fn) >= DW'(fl)) ? rdb_reg : '0);
        end
    end

    assign cand     = (m_reg == '0) ? '0 : rdb_reg;
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.fill_wr)
        begin
            mem[fill_reg] <= fill_val;
        end
        rda_reg <= mem[addr_a];
        rdb_reg <= mem[addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.fill_wr)
            begin
                fill_reg <= fill_reg + IW'(1);
            end
            if (cmd.take_part || cmd.emit_one)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            n_reg     <= NW'(in_n);
            l_reg     <= LW'(in_l);
            m_reg     <= MW'(in_m);
            frac_reg  <= in_data[49:18];
            range_reg <= (32'(in_n) > MAX_N) || (32'(in_l) > MAX_LIMIT) ||
                         (32'(in_m) > MAX_PARTS);
            k_reg     <= '0;
        end
        if (cmd.cap_total)
        begin
            total_reg <= rda_reg;
        end
        if (cmd.mul)
        begin
            prod_reg <= {{COUNT_W{1'b0}}, frac_reg} * {{COUNT_W{1'b0}}, total_reg};
        end
        // Rank is the ceiling of fraction times count, so 1 to count.
        if (cmd.set_which)
        begin
            which_reg <= prod_reg[2*COUNT_W-1:COUNT_W] + COUNT_W'(|prod_reg[COUNT_W-1:0]);
        end
        if (cmd.walk_init)
        begin
            i_reg <= LW'(1);
        end
        if (cmd.walk_step)
        begin
            which_reg <= which_reg - cand;
            i_reg     <= i_reg + LW'(1);
        end
        if (cmd.take_part)
        begin
            n_reg <= n_diff[NW-1:0];
            l_reg <= i_reg;
            m_reg <= m_reg - MW'(1);
            k_reg <= k_reg + KW'(1);
        end
        if (cmd.take_part)
        begin
            out_count_reg  <= total_reg;
            out_part_reg   <= PART_W'(i_reg);
            out_pvalid_reg <= 1'b1;
            out_last_reg   <= status.part_last;
            out_err_reg    <= ERR_OK;
        end
        else if (cmd.emit_one)
        begin
            out_part_reg   <= '0;
            out_pvalid_reg <= 1'b0;
            out_last_reg   <= 1'b1;
            case (cmd.kind)
                EMIT_RANGE:
                begin
                    out_count_reg <= '0;
                    out_err_reg   <= ERR_RANGE;
                end
                EMIT_EMPTY:
                begin
                    out_count_reg <= '0;
                    out_err_reg   <= ERR_OK;
                end
                EMIT_ZFRAC:
                begin
                    out_count_reg <= total_reg;
                    out_err_reg   <= ERR_ZERO_FRAC;
                end
                default:
                begin
                    out_count_reg <= total_reg;
                    out_err_reg   <= ERR_OK;
                end
            endcase
        end
    end

    assign status.fill_last  = (fill_reg == '1);
    assign status.range_err  = range_reg;
    assign status.total_zero = (total_reg == '0);
    assign status.frac_zero  = (frac_reg == '0);
    assign status.n_zero     = (n_reg == '0);
    assign status.walk_hit   = (cand >= which_reg) || (DW'(i_reg) == top);
    assign status.part_last  = (n_diff == '0) || (k_reg == KW'(MAX_RESULTS - 1));
    assign status.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign out_data  = {out_err_reg, out_pvalid_reg, out_part_reg, out_count_reg};

endmodule

// File: rtl/restricted_partition_count_unrank.sv
// After reset the count table is filled, each entry read and then written, during which
// no query is taken. A query then gives a single result in the special cases; else the
// count and fraction give a rank, and each part is found by a walk over candidate part
// values through the registered table read port, and then emitted. One query at a time;
// results sit in an output register. Reset is async, active low.
// ----------------------------------------------------------------------------
// restricted_partition_count_unrank
// Counts restricted integer partitions and emits a partition chosen by rank.
// ----------------------------------------------------------------------------
module restricted_partition_count_unrank
    import rpcu_pkg::*;
#(
    parameter int MAX_N     = MAX_N_DEF,
    parameter int MAX_LIMIT = MAX_LIMIT_DEF,
    parameter int MAX_PARTS = MAX_PARTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // total_size[5:0], largest_part_limit[11:6], part_count_limit[17:12],
    // rand_fraction[49:18], zero fill above
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // partition_count[31:0], part_value[36:32], part_valid[37], error_code[39:38]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    cmd_t    cmd;
    status_t status;

    rpcu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rpcu_datapath #(
        .MAX_N     (MAX_N),
        .MAX_LIMIT (MAX_LIMIT),
        .MAX_PARTS (MAX_PARTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// File: rtl/rpcu_checker.sv
// ----------------------------------------------------------------------------
// rpcu_checker
// Port-level checks on the result stream of the partition unranker.
// ----------------------------------------------------------------------------
`include "restricted_partition_count_unrank_defines.svh"

module rpcu_checker
    import rpcu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    `RPCU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `RPCU_ASSERT_HOLD(a_err_code, clk, rst_n, !m_tvalid || m_tdata[39:38] != 2'd3)
    `RPCU_ASSERT_HOLD(a_nopart_last, clk, rst_n, !m_tvalid || m_tdata[37] || (m_tlast && m_tdata[36:32] == 5'd0))
    `RPCU_ASSERT_HOLD(a_err_single, clk, rst_n, !m_tvalid || m_tdata[39:38] == 2'd0 || (m_tlast && !m_tdata[37]))

endmodule

bind restricted_partition_count_unrank rpcu_checker u_rpcu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
